// File: hw/rtl/agc_pkg.sv
// Shared types and constants for the anagram group checker.
// Used by every module under hw/rtl; depends on nothing.
package agc_pkg;

    localparam int DefaultWords  = 5;
    localparam int DefaultMaxLen = 32;
    localparam int SymbolWidth   = 8;
    localparam int HistDepth     = 256;
    localparam int HistAw        = 8;
    localparam int QueueDepth    = 4;

    typedef struct packed {
        logic [SymbolWidth-1:0] symbol;
        logic                   word_end;
    } item_t;

    typedef struct packed {
        logic lengths_equal;
        logic all_anagrams;
        logic too_long;
    } result_t;

    typedef struct packed {
        logic [SymbolWidth-1:0] symbol;
        logic                   count_en;
        logic                   to_first;
        logic                   end_later;
        logic                   last;
        logic                   len_eq;
        logic                   ovf;
    } cmd_t;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_INC,
        B_SCAN,
        B_TAIL
    } back_state_t;

endpackage

// File: hw/rtl/agc_front.sv
// Front end: accepts requests, tracks word index and lengths, builds commands.
// Depends on agc_pkg.
module agc_front #(
    parameter int WORDS   = agc_pkg::DefaultWords,
    parameter int MAX_LEN = agc_pkg::DefaultMaxLen
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  agc_pkg::item_t item,
    input  logic          q_full,
    input  logic          init_done,
    output logic          busy,
    output logic          push,
    output agc_pkg::cmd_t cmd
);

    localparam int LW  = $clog2(MAX_LEN + 1);
    localparam int WCW = $clog2(WORDS);
    localparam logic [LW-1:0]  MaxLen   = LW'(MAX_LEN);
    localparam logic [WCW-1:0] LastWord = WCW'(WORDS - 1);

    logic [WCW-1:0] word_idx_reg, word_idx_next;
    logic [LW-1:0]  first_len_reg, first_len_next;
    logic [LW-1:0]  cur_len_reg, cur_len_next;
    logic           len_eq_reg, len_eq_next;
    logic           ovf_reg, ovf_next;

    logic           first;
    logic           last;
    logic           cnt_en;
    logic [LW-1:0]  len;
    logic [LW-1:0]  new_len;
    logic           len_eq_upd;
    logic           ovf_upd;

    assign busy = q_full | ~init_done;
    assign push = start & ~busy;

    always_comb
    begin
        first      = (word_idx_reg == '0);
        last       = (word_idx_reg == LastWord);
        len        = first ? first_len_reg : cur_len_reg;
        cnt_en     = (len < MaxLen);
        new_len    = cnt_en ? LW'(len + LW'(1)) : len;
        ovf_upd    = ovf_reg | ~cnt_en;
        len_eq_upd = len_eq_reg & (new_len == first_len_reg);

        word_idx_next  = word_idx_reg;
        first_len_next = first_len_reg;
        cur_len_next   = cur_len_reg;
        len_eq_next    = len_eq_reg;
        ovf_next       = ovf_reg;

        if (push)
        begin
            ovf_next = ovf_upd;
            if (first)
            begin
                first_len_next = new_len;
                if (item.word_end)
                begin
                    word_idx_next = WCW'(1);
                end
            end
            else if (!item.word_end)
            begin
                cur_len_next = new_len;
            end
            else if (last)
            begin
                word_idx_next  = '0;
                first_len_next = '0;
                cur_len_next   = '0;
                len_eq_next    = 1'b1;
                ovf_next       = 1'b0;
            end
            else
            begin
                word_idx_next = WCW'(word_idx_reg + WCW'(1));
                cur_len_next  = '0;
                len_eq_next   = len_eq_upd;
            end
        end

        cmd.symbol    = item.symbol;
        cmd.count_en  = cnt_en;
        cmd.to_first  = first;
        cmd.end_later = item.word_end & ~first;
        cmd.last      = item.word_end & ~first & last;
        cmd.len_eq    = len_eq_upd;
        cmd.ovf       = ovf_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_idx_reg  <= '0;
            first_len_reg <= '0;
            cur_len_reg   <= '0;
            len_eq_reg    <= 1'b1;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            word_idx_reg  <= word_idx_next;
            first_len_reg <= first_len_next;
            cur_len_reg   <= cur_len_next;
            len_eq_reg    <= len_eq_next;
            ovf_reg       <= ovf_next;
        end
    end

endmodule

// File: hw/rtl/agc_queue.sv
// Short command queue between front and back ends.
// Depends on agc_pkg.
module agc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  agc_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          valid,
    output agc_pkg::cmd_t head
);

    localparam int Depth = agc_pkg::QueueDepth;
    localparam int PW    = $clog2(Depth);

    agc_pkg::cmd_t   slot_reg [Depth];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;

    assign full  = (count_reg == (PW+1)'(Depth));
    assign valid = (count_reg != '0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PW'(wr_ptr_reg + PW'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? PW'(rd_ptr_reg + PW'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = (PW+1)'(count_reg + (PW+1)'(1));
        end
        else if (pop && !push)
        begin
            count_next = (PW+1)'(count_reg - (PW+1)'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/agc_back.sv
// Back end: histogram memories, increments, compare-and-clear scan, result.
// Depends on agc_pkg.
module agc_back #(
    parameter int MAX_LEN = agc_pkg::DefaultMaxLen
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  agc_pkg::cmd_t    q_head,
    output logic             pop,
    output logic             init_done,
    output logic             done,
    output agc_pkg::result_t result
);

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int AW = agc_pkg::HistAw;
    localparam int HD = agc_pkg::HistDepth;
    localparam logic [AW-1:0] LastAddr = AW'(HD - 1);

    logic [CW-1:0] first_mem [HD];
    logic [CW-1:0] cur_mem   [HD];

    agc_pkg::back_state_t state_reg, state_next;
    logic [AW-1:0]    addr_reg, addr_next;
    agc_pkg::cmd_t    cmd_reg, cmd_next;
    logic [CW-1:0]    first_rd_reg;
    logic [CW-1:0]    cur_rd_reg;
    logic             cmp_valid_reg, cmp_valid_next;
    logic             mismatch_reg, mismatch_next;
    logic             anagram_reg, anagram_next;
    logic             done_reg, done_next;
    agc_pkg::result_t result_reg, result_next;

    logic [AW-1:0]    mem_addr;
    logic             first_we;
    logic             cur_we;
    logic [CW-1:0]    wdata;
    logic             mism_final;

    assign init_done = (state_reg != agc_pkg::B_INIT);
    assign done      = done_reg;
    assign result    = result_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            agc_pkg::B_INIT:
            begin
                if (addr_reg == LastAddr)
                begin
                    state_next = agc_pkg::B_IDLE;
                end
            end
            agc_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_head.count_en)
                    begin
                        state_next = agc_pkg::B_INC;
                    end
                    else if (q_head.end_later)
                    begin
                        state_next = agc_pkg::B_SCAN;
                    end
                end
            end
            agc_pkg::B_INC:
            begin
                state_next = cmd_reg.end_later ? agc_pkg::B_SCAN : agc_pkg::B_IDLE;
            end
            agc_pkg::B_SCAN:
            begin
                if (addr_reg == LastAddr)
                begin
                    state_next = agc_pkg::B_TAIL;
                end
            end
            agc_pkg::B_TAIL:
            begin
                state_next = agc_pkg::B_IDLE;
            end
            default:
            begin
                state_next = agc_pkg::B_INIT;
            end
        endcase
    end

    always_comb
    begin
        pop            = 1'b0;
        mem_addr       = addr_reg;
        first_we       = 1'b0;
        cur_we         = 1'b0;
        wdata          = '0;
        addr_next      = addr_reg;
        cmd_next       = cmd_reg;
        cmp_valid_next = 1'b0;
        mism_final     = mismatch_reg | (cmp_valid_reg & (first_rd_reg != cur_rd_reg));
        mismatch_next  = mism_final;
        anagram_next   = anagram_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        case (state_reg)
            agc_pkg::B_INIT:
            begin
                first_we  = 1'b1;
                cur_we    = 1'b1;
                addr_next = AW'(addr_reg + AW'(1));
            end
            agc_pkg::B_IDLE:
            begin
                mem_addr  = q_head.symbol;
                addr_next = '0;
                if (q_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = q_head;
                end
            end
            agc_pkg::B_INC:
            begin
                mem_addr = cmd_reg.symbol;
                first_we = cmd_reg.to_first;
                cur_we   = ~cmd_reg.to_first;
                wdata    = CW'((cmd_reg.to_first ? first_rd_reg : cur_rd_reg) + CW'(1));
            end
            agc_pkg::B_SCAN:
            begin
                first_we       = cmd_reg.last;
                cur_we         = 1'b1;
                cmp_valid_next = 1'b1;
                addr_next      = AW'(addr_reg + AW'(1));
            end
            agc_pkg::B_TAIL:
            begin
                mismatch_next = 1'b0;
                if (cmd_reg.last)
                begin
                    done_next                 = 1'b1;
                    result_next.lengths_equal = cmd_reg.len_eq;
                    result_next.all_anagrams  = anagram_reg & ~mism_final;
                    result_next.too_long      = cmd_reg.ovf;
                    anagram_next              = 1'b1;
                end
                else
                begin
                    anagram_next = anagram_reg & ~mism_final;
                end
            end
            default:
            begin
                mismatch_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        first_rd_reg <= first_mem[mem_addr];
        cur_rd_reg   <= cur_mem[mem_addr];
        if (first_we)
        begin
            first_mem[mem_addr] <= wdata;
        end
        if (cur_we)
        begin
            cur_mem[mem_addr] <= wdata;
        end
        cmd_reg    <= cmd_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= agc_pkg::B_INIT;
            addr_reg      <= '0;
            cmp_valid_reg <= 1'b0;
            mismatch_reg  <= 1'b0;
            anagram_reg   <= 1'b1;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            cmp_valid_reg <= cmp_valid_next;
            mismatch_reg  <= mismatch_next;
            anagram_reg   <= anagram_next;
            done_reg      <= done_next;
        end
    end

endmodule

// File: hw/rtl/anagram_group_check.sv
// Top level of the anagram group checker: front end, command queue, back end.
// Depends on agc_pkg, agc_front, agc_queue and agc_back.
//
//   channel   ports                      taken when
//   request   start, busy, item          start high and busy low at clk rise
//   result    done, result               done high, one cycle, no stall
//
// In the back end a counted character takes a memory read, then a write of the
// incremented count. The end of every word after the first adds a 256-entry
// compare-and-clear scan plus a tail state; that scan of the histogram memories
// sets the rate. After reset the back end clears all 256 entries of both
// memories with busy high. A 4-deep command queue lets requests flow in while a
// scan runs; once that clearing is done, busy rises only when it is full.
module anagram_group_check #(
    parameter int WORDS   = agc_pkg::DefaultWords,
    parameter int MAX_LEN = agc_pkg::DefaultMaxLen
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  agc_pkg::item_t   item,
    output logic             done,
    output agc_pkg::result_t result
);

    logic          push;
    agc_pkg::cmd_t push_cmd;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    agc_pkg::cmd_t q_head;
    logic          init_done;

    agc_front #(
        .WORDS   (WORDS),
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .q_full    (q_full),
        .init_done (init_done),
        .busy      (busy),
        .push      (push),
        .cmd       (push_cmd)
    );

    agc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (q_head)
    );

    agc_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (q_pop),
        .init_done (init_done),
        .done      (done),
        .result    (result)
    );

endmodule

// File: tb/anagram_group_check_test.sv
// Self-checking testbench for anagram_group_check: drives word groups and checks every verdict.
// Holds its own predictor of the group verdicts; depends on agc_pkg and the RTL under hw/rtl.
module anagram_group_check_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef agc_pkg::item_t   item_t;
    typedef agc_pkg::result_t result_t;

    localparam int Words      = agc_pkg::DefaultWords;
    localparam int MaxLen     = agc_pkg::DefaultMaxLen;
    localparam int ItemTarget = 1700;
    localparam int StallLimit = 20000;
    localparam int TailCycles = 600;

    localparam result_t AllMatch = result_t'{1'b1, 1'b1, 1'b0};
    localparam result_t LenMatch = result_t'{1'b1, 1'b0, 1'b0};
    localparam result_t NoMatch  = result_t'{1'b0, 1'b0, 1'b0};

    localparam string FieldName [3] = '{"too_long", "all_anagrams", "lengths_equal"};

    typedef struct packed {
        item_t   req;
        logic    typed;
        result_t verdict;
    } row_t;

    localparam row_t Directed [24] = '{
        '{item_t'{8'h00, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'h00, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'h00, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'h00, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'h00, 1'b1}, 1'b1, AllMatch},
        '{item_t'{8'hff, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'hff, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'hff, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'hff, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'hff, 1'b1}, 1'b1, AllMatch},
        '{item_t'{8'h01, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'h80, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'h7f, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'hfe, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'h01, 1'b1}, 1'b1, LenMatch},
        '{item_t'{8'h78, 1'b0}, 1'b0, NoMatch},
        '{item_t'{8'h79, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'h79, 1'b0}, 1'b0, NoMatch},
        '{item_t'{8'h78, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'h79, 1'b0}, 1'b0, NoMatch},
        '{item_t'{8'h78, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'h78, 1'b0}, 1'b0, NoMatch},
        '{item_t'{8'h79, 1'b1}, 1'b0, NoMatch},
        '{item_t'{8'h78, 1'b1}, 1'b1, NoMatch}
    };

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    item_t   item  = '0;
    logic    done;
    result_t result;

    logic [5:0] first_hist [agc_pkg::HistDepth];
    logic [5:0] word_hist  [agc_pkg::HistDepth];
    int         word_no;
    int         first_len;
    int         word_len;
    bit         len_ok;
    bit         same_letters;
    bit         overlong;

    result_t verdicts_due [$];
    int      mismatches = 0;
    int      sent       = 0;
    int      quiet      = 0;
    int      groups     = 0;
    bit      gaps_on    = 1'b1;

    anagram_group_check #(
        .WORDS   (Words),
        .MAX_LEN (MaxLen)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #5ns clk = ~clk;

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t: mismatch: %s", $realtime, what);
    endtask

    task automatic clear_group();
        foreach (first_hist[s])
        begin
            first_hist[s] = '0;
            word_hist[s]  = '0;
        end
        word_no      = 0;
        first_len    = 0;
        word_len     = 0;
        len_ok       = 1'b1;
        same_letters = 1'b1;
        overlong     = 1'b0;
    endtask

    task automatic tally_char(input item_t it, output bit closes, output result_t verdict);
        bit leading;
        leading = (word_no == 0);
        closes  = 1'b0;
        verdict = '0;
        if ((leading ? first_len : word_len) < MaxLen)
        begin
            if (leading)
            begin
                first_len++;
                first_hist[it.symbol] += 6'd1;
            end
            else
            begin
                word_len++;
                word_hist[it.symbol] += 6'd1;
            end
        end
        else
            overlong = 1'b1;
        if (it.word_end)
        begin
            if (leading)
                word_no = 1;
            else
            begin
                if (word_len != first_len)
                    len_ok = 1'b0;
                foreach (word_hist[s])
                begin
                    if (word_hist[s] != first_hist[s])
                        same_letters = 1'b0;
                    word_hist[s] = '0;
                end
                word_len = 0;
                if (word_no + 1 >= Words)
                begin
                    closes  = 1'b1;
                    verdict = result_t'{len_ok, same_letters, overlong};
                    clear_group();
                end
                else
                    word_no++;
            end
        end
    endtask

    // hold start until the request is taken, then advance the predictor
    task automatic send_req(input item_t it, input bit typed, input result_t typed_verdict);
        bit      closes;
        result_t verdict;
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 24)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        tally_char(it, closes, verdict);
        if (closes)
            verdicts_due.push_back(typed ? typed_verdict : verdict);
        sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_word(input logic [7:0] chars [$]);
        foreach (chars[i])
            send_req(item_t'{chars[i], i == chars.size() - 1}, 1'b0, NoMatch);
    endtask

    function automatic logic [7:0] pick_symbol(input bit narrow);
        return narrow ? 8'(8'h61 + $urandom_range(3)) : 8'($urandom_range(255));
    endfunction

    task automatic send_group();
        logic [7:0] base [$];
        logic [7:0] chars [$];
        logic [7:0] held;
        int         kind;
        int         len;
        int         j;
        bit         narrow;
        kind   = $urandom_range(19);
        narrow = 1'($urandom_range(1));
        len    = (kind == 19) ? $urandom_range(MaxLen - 1, MaxLen + 8) : $urandom_range(1, 8);
        repeat (len) base.push_back(pick_symbol(narrow));
        send_word(base);
        for (int n = 1; n < Words; n++)
        begin
            chars = base;
            if (kind >= 12 && kind <= 15)
            begin
                chars.delete();
                if ($urandom_range(1) == 0)
                    len = base.size();
                else
                    len = $urandom_range(1, ($urandom_range(5) == 0) ? MaxLen + 4 : 8);
                repeat (len) chars.push_back(pick_symbol(narrow));
            end
            else
            begin
                for (int i = chars.size() - 1; i > 0; i--)
                begin
                    j        = $urandom_range(i);
                    held     = chars[i];
                    chars[i] = chars[j];
                    chars[j] = held;
                end
                if ($urandom_range(4) == 0)
                begin
                    case ($urandom_range(2))
                        0: chars[$urandom_range(chars.size() - 1)] = pick_symbol(narrow);
                        1: chars.push_back(pick_symbol(narrow));
                        default: if (chars.size() > 1) void'(chars.pop_back());
                    endcase
                end
            end
            send_word(chars);
        end
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done === 1'b1)
        begin
            if (verdicts_due.size() == 0)
                flag_mismatch($sformatf("verdict %b with no request pending", result));
            else
            begin
                want = verdicts_due.pop_front();
                for (int f = 2; f >= 0; f--)
                    if (result[f] !== want[f])
                        flag_mismatch($sformatf("%s is %b, expected %b",
                                                FieldName[f], result[f], want[f]));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || done === 1'b1)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= StallLimit)
        begin
            $display("anagram_group_check regression: fail");
            $finish;
        end
    end

    initial
    begin
        clear_group();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (Directed[r])
            send_req(Directed[r].req, Directed[r].typed, Directed[r].verdict);
        drain();
        while (sent < ItemTarget)
        begin
            groups++;
            gaps_on = !(groups >= 15 && groups < 27);
            send_group();
            if ($urandom_range(7) == 0)
                drain();
        end
        drain();
        repeat (TailCycles) @(posedge clk);
        if (mismatches == 0)
            $display("anagram_group_check regression: pass");
        else
            $display("anagram_group_check regression: fail");
        $finish;
    end

endmodule
